// ----- src/rvx_pkg.sv -----
// shared types and constants for the rv32i execute block
package rvx_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = 5;

  localparam logic [6:0] OPC_MASK   = 7'h7F;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;
  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic CMD_INSTR = 1'b0;
  localparam logic CMD_LDATA = 1'b1;

  localparam logic CFG_RESET_PC = 1'b0;
  localparam logic CFG_INIT_SP  = 1'b1;
  localparam logic [REG_IDX_W-1:0] SP_IDX = 5'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instr;
    logic [31:0] ldata;
  } item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] rd;
    logic [1:0]           size;
    logic                 uns;
    logic                 valid;
  } ld_state_t;

  typedef struct packed {
    logic [31:0]          next_pc;
    logic                 mem_valid;
    logic                 mem_write;
    logic [31:0]          mem_addr;
    logic [1:0]           mem_size;
    logic [31:0]          mem_wdata;
    logic                 rd_write;
    logic [REG_IDX_W-1:0] rd_index;
    logic [31:0]          rd_value;
    logic                 halted;
    logic                 waiting_load;
  } result_t;

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    case (size)
      SIZE_BYTE: size_mask = 32'h0000_00FF;
      SIZE_HALF: size_mask = 32'h0000_FFFF;
      default:   size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

// ----- src/rvx_regfile.sv -----
// register file: two synchronous copies, valid bits and write forwarding
module rvx_regfile import rvx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] ra1,
  input  logic [REG_IDX_W-1:0] ra2,
  input  logic                 we,
  input  logic [REG_IDX_W-1:0] wa,
  input  logic [31:0]          wd,
  output logic [31:0]          rs1v,
  output logic [31:0]          rs2v
);

  logic [31:0]          mem1 [REG_COUNT];
  logic [31:0]          mem2 [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]          q1_r, q2_r, fv_r;
  logic                 v1_r, v2_r, f1_r, f2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem1[wa] <= wd;
      mem2[wa] <= wd;
    end
    if (rd_en) begin
      q1_r <= mem1[ra1];
      q2_r <= mem2[ra2];
      fv_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      f1_r <= 1'b0;
      f2_r <= 1'b0;
    end else begin
      if (we) valid_r[wa] <= 1'b1;
      if (rd_en) begin
        // indexes beyond the register count always read zero
        v1_r <= (32'(ra1) < REG_COUNT) && valid_r[ra1];
        v2_r <= (32'(ra2) < REG_COUNT) && valid_r[ra2];
        f1_r <= we && (wa == ra1);
        f2_r <= we && (wa == ra2);
      end
    end
  end

  // unwritten entries read zero, x0 is never written
  assign rs1v = f1_r ? fv_r : (v1_r ? q1_r : 32'h0);
  assign rs2v = f2_r ? fv_r : (v2_r ? q2_r : 32'h0);

endmodule

// ----- src/rvx_exec.sv -----
// decode and execute of one transaction
module rvx_exec import rvx_pkg::*; (
  input  item_t       item,
  input  logic [31:0] rs1v,
  input  logic [31:0] rs2v,
  input  logic [31:0] pc,
  input  ld_state_t   ld,
  input  logic        halt,
  output result_t     res,
  output ld_state_t   ld_nxt,
  output logic        halt_nxt,
  output logic        pc_we
);

  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] ir, immi, imms, immb, immj, immu, alu_b, alu_r, ldv, pc4;
  logic        has_res, take, alt, ok;

  always_comb begin
    ir   = item.instr;
    op   = ir[6:0] & OPC_MASK;
    rd   = ir[11:7];
    f3   = ir[14:12];
    f7   = ir[31:25];
    immi = {{20{ir[31]}}, ir[31:20]};
    imms = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    immb = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    immj = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    immu = {ir[31:12], 12'h000};
    pc4  = pc + 32'd4;

    alu_b = (op == OPC_OP) ? rs2v : immi;
    alt   = (f7 == F7_ALT);
    case (f3)
      3'd0: alu_r = (alt && op == OPC_OP) ? rs1v - alu_b : rs1v + alu_b;
      3'd1: alu_r = rs1v << alu_b[4:0];
      3'd2: alu_r = {31'h0, $signed(rs1v) < $signed(alu_b)};
      3'd3: alu_r = {31'h0, rs1v < alu_b};
      3'd4: alu_r = rs1v ^ alu_b;
      3'd5: alu_r = alt ? 32'($signed(rs1v) >>> alu_b[4:0]) : rs1v >> alu_b[4:0];
      3'd6: alu_r = rs1v | alu_b;
      default: alu_r = rs1v & alu_b;
    endcase

    case (f3)
      3'd0: take = rs1v == rs2v;
      3'd1: take = rs1v != rs2v;
      3'd4: take = $signed(rs1v) < $signed(rs2v);
      3'd5: take = !($signed(rs1v) < $signed(rs2v));
      3'd6: take = rs1v < rs2v;
      3'd7: take = rs1v >= rs2v;
      default: take = 1'b0;
    endcase

    ldv = item.ldata & size_mask(ld.size);
    if (!ld.uns && ld.size == SIZE_BYTE) ldv = {{24{ldv[7]}}, ldv[7:0]};
    if (!ld.uns && ld.size == SIZE_HALF) ldv = {{16{ldv[15]}}, ldv[15:0]};

    res      = '0;
    res.next_pc = pc;
    ld_nxt   = ld;
    halt_nxt = halt;
    pc_we    = 1'b0;
    has_res  = 1'b0;
    ok       = 1'b0;

    if (item.cmd == CMD_LDATA) begin
      if (ld.valid) begin
        res.rd_index = ld.rd;
        res.rd_value = ldv;
        ok = 1'b1;
        ld_nxt.valid = 1'b0;
      end
    end else if (!ld.valid && !halt) begin
      pc_we = 1'b1;
      res.next_pc = pc4;
      res.rd_index = rd;
      unique case (op)
        OPC_OP: begin
          if (f7 == F7_ZERO || (alt && (f3 == 3'd0 || f3 == 3'd5))) begin
            has_res = 1'b1;
            res.rd_value = alu_r;
          end
        end
        OPC_OPIMM: begin
          if ((f3 == 3'd1 && f7 == F7_ZERO) ||
              (f3 == 3'd5 && (f7 == F7_ZERO || alt)) ||
              (f3 != 3'd1 && f3 != 3'd5)) begin
            has_res = 1'b1;
            res.rd_value = (f3 == 3'd5 || f3 == 3'd1 || !alt || f3 != 3'd5) ?
                           alu_r : alu_r;
          end
        end
        OPC_LOAD: begin
          if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
            res.mem_valid = 1'b1;
            res.mem_addr  = rs1v + immi;
            res.mem_size  = f3[1:0];
            ld_nxt.rd     = rd;
            ld_nxt.size   = f3[1:0];
            ld_nxt.uns    = f3[2];
            ld_nxt.valid  = 1'b1;
          end
        end
        OPC_STORE: begin
          if (f3 <= 3'd2) begin
            res.mem_valid = 1'b1;
            res.mem_write = 1'b1;
            res.mem_addr  = rs1v + imms;
            res.mem_size  = f3[1:0];
            res.mem_wdata = rs2v & size_mask(f3[1:0]);
          end
        end
        OPC_BRANCH: if (take) res.next_pc = pc + immb;
        OPC_JAL: begin
          has_res = 1'b1;
          res.rd_value = pc4;
          res.next_pc = pc + immj;
        end
        OPC_JALR: begin
          if (f3 == 3'd0) begin
            has_res = 1'b1;
            res.rd_value = pc4;
            res.next_pc = (rs1v + immi) & ~32'h1;
          end
        end
        OPC_LUI: begin
          has_res = 1'b1;
          res.rd_value = immu;
        end
        OPC_AUIPC: begin
          has_res = 1'b1;
          res.rd_value = pc + immu;
        end
        OPC_SYSTEM: if (ir == INSTR_EBREAK) halt_nxt = 1'b1;
        default: ;
      endcase
      ok = has_res;
    end

    res.rd_write = ok && (res.rd_index != '0) && (32'(res.rd_index) < REG_COUNT);
    if (!res.rd_write) begin
      res.rd_index = '0;
      res.rd_value = '0;
    end
    res.halted       = halt_nxt;
    res.waiting_load = ld_nxt.valid;
  end

endmodule

// ----- src/rv32i_instruction_execute_top.sv -----
// top level of the rv32i instruction execute block
//
// usage:
// - in channel: one transaction is an instruction word (in_cmd 0) or the
//   data word of a waiting load (in_cmd 1); out channel returns exactly one
//   result transaction for each input transaction, in order
// - cfg channel: index 0 writes reset_pc and loads the pc, index 1 writes
//   initial_stack_pointer and loads x2; cfg_ready is always high, write
//   only while the block is idle
// - pipeline: the accepting edge registers the transaction in the operand
//   stage and also reads the two register file copies (synchronous read);
//   the operand stage then executes, registers the result and writes rd back
// - throughput: one transaction per cycle while out_ready is high; a result
//   written back in the same cycle as the next read is forwarded to that read
// - reset: pc, pending load and halt flag clear, all registers read zero
//   through per-entry valid bits, so no clearing pass is needed
// - stall: while out_ready is low the result register holds, the operand
//   stage holds one more transaction, and then in_ready drops
module rv32i_instruction_execute_top import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_mem_valid,
  output logic        out_mem_write,
  output logic [31:0] out_mem_addr,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_wdata,
  output logic        out_rd_write,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_value,
  output logic        out_halted,
  output logic        out_waiting_load,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  item_t     s1_r;
  logic      s1_v_r, ov_r;
  result_t   out_r, res;
  logic [31:0] pc_r, rs1v, rs2v;
  ld_state_t ld_r, ld_nxt;
  logic      halt_r, halt_nxt, pc_we;
  logic      accept, advance, cfg_wr, sp_wr, rf_we;
  logic [REG_IDX_W-1:0] rf_wa;
  logic [31:0]          rf_wd;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign sp_wr     = cfg_wr && cfg_index == CFG_INIT_SP;

  // operand stage moves on when the result register is free or drains
  assign advance  = s1_v_r && (!ov_r || out_ready);
  assign in_ready = !s1_v_r || advance;
  assign accept   = in_valid && in_ready;

  // single write port, config wins: the user keeps config writes of x2 only while idle; the block does not enforce it
  assign rf_we = sp_wr || (advance && res.rd_write);
  assign rf_wa = sp_wr ? SP_IDX : res.rd_index;
  assign rf_wd = sp_wr ? cfg_data : res.rd_value;

  rvx_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (accept),
    .ra1   (in_instr_word[19:15]),
    .ra2   (in_instr_word[24:20]),
    .we    (rf_we),
    .wa    (rf_wa),
    .wd    (rf_wd),
    .rs1v  (rs1v),
    .rs2v  (rs2v)
  );

  rvx_exec u_exec (
    .item     (s1_r),
    .rs1v     (rs1v),
    .rs2v     (rs2v),
    .pc       (pc_r),
    .ld       (ld_r),
    .halt     (halt_r),
    .res      (res),
    .ld_nxt   (ld_nxt),
    .halt_nxt (halt_nxt),
    .pc_we    (pc_we)
  );

  // operand stage payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.cmd   <= in_cmd;
      s1_r.instr <= in_instr_word;
      s1_r.ldata <= in_load_data;
    end
    if (advance) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
      pc_r   <= '0;
      ld_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      if (accept) s1_v_r <= 1'b1;
      else if (advance) s1_v_r <= 1'b0;
      if (advance) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cfg_wr && cfg_index == CFG_RESET_PC) pc_r <= cfg_data;
      else if (advance && pc_we) pc_r <= res.next_pc;
      if (advance) begin
        ld_r   <= ld_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_next_pc      = out_r.next_pc;
  assign out_mem_valid    = out_r.mem_valid;
  assign out_mem_write    = out_r.mem_write;
  assign out_mem_addr     = out_r.mem_addr;
  assign out_mem_size     = out_r.mem_size;
  assign out_mem_wdata    = out_r.mem_wdata;
  assign out_rd_write     = out_r.rd_write;
  assign out_rd_index     = out_r.rd_index;
  assign out_rd_value     = out_r.rd_value;
  assign out_halted       = out_r.halted;
  assign out_waiting_load = out_r.waiting_load;

  // x0 is never written back
  a_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.rd_write) |-> res.rd_index != '0)
    else $error("write to x0");

  // halt flag is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");

  // an instruction while a load waits changes nothing
  a_wait_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ld_r.valid && s1_r.cmd == CMD_INSTR) |-> !res.rd_write && !pc_we)
    else $error("instruction executed during pending load");

endmodule
